// ===== sv/lmdrt_pkg.sv =====
// Shared types, constants and defaults for the local maximum dynamic-range truncation core.
package lmdrt_pkg;

  localparam int unsigned DEF_SUBSAMPLING = 2;
  localparam int unsigned DEF_NUM_REGIONS = 4;
  localparam int unsigned DEF_GRID_Z      = 128;
  localparam int unsigned DEF_GRID_R      = 128;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned REGION_W = 2;
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned FIELD_W  = 24;
  localparam int unsigned DR_W     = 10;
  localparam int unsigned FLOOR_W  = 23;
  localparam int unsigned SQ_W     = 47;
  localparam int unsigned MAG2_W   = 48;
  localparam int unsigned FL2_W    = 46;
  localparam int unsigned LIM_W    = 24;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic REG_DYN_RANGE = 1'b0;
  localparam logic REG_FLOOR     = 1'b1;

  localparam logic [DR_W-1:0]    DYN_RANGE_RST = 10'd50;
  localparam logic [FLOOR_W-1:0] FLOOR_RST     = 23'd0;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_ACCUM  = 2'd1,
    OP_THRESH = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_FETCH,
    ST_EXEC
  } state_e;

  typedef struct packed {
    op_e                       op;
    logic                      cell_ok;
    logic signed [FIELD_W-1:0] e_r;
    logic signed [FIELD_W-1:0] e_z;
    logic [SQ_W-1:0]           sq_r;
    logic [SQ_W-1:0]           sq_z;
    logic [LIM_W-1:0]          lim_r;
    logic [LIM_W-1:0]          lim_z;
    logic                      lim_r_big;
    logic                      lim_z_big;
  } item_t;

endpackage

// ===== sv/lmdrt_front.sv =====
// Front end: input register, cell address decode, magnitudes and range-scaled limits.
module lmdrt_front import lmdrt_pkg::*; #(
  parameter int unsigned SUBSAMPLING = DEF_SUBSAMPLING,
  parameter int unsigned NUM_REGIONS = DEF_NUM_REGIONS,
  parameter int unsigned GRID_Z      = DEF_GRID_Z,
  parameter int unsigned GRID_R      = DEF_GRID_R,
  parameter int unsigned CELLS_Z     = (GRID_Z + SUBSAMPLING - 1) / SUBSAMPLING,
  parameter int unsigned CELLS_R     = (GRID_R + SUBSAMPLING - 1) / SUBSAMPLING,
  parameter int unsigned ADDR_W      = 14
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      s_valid_i,
  output logic                      s_ready_o,
  input  logic [OP_W-1:0]           op_i,
  input  logic [REGION_W-1:0]       region_i,
  input  logic [IDX_W-1:0]          z_index_i,
  input  logic [IDX_W-1:0]          r_index_i,
  input  logic signed [FIELD_W-1:0] e_r_i,
  input  logic signed [FIELD_W-1:0] e_z_i,
  input  logic [DR_W-1:0]           dyn_range_i,
  output logic                      push_o,
  input  logic                      push_ready_i,
  output item_t                     item_o,
  output logic [ADDR_W-1:0]         addr_o
);

  localparam int unsigned DIV_SH    = 11;
  localparam int unsigned DIV_RECIP = ((1 << DIV_SH) + SUBSAMPLING - 1) / SUBSAMPLING;
  localparam int unsigned PROD_W    = FIELD_W + DR_W;

  logic                      f_valid_q;
  logic [OP_W-1:0]           f_op_q;
  logic [REGION_W-1:0]       f_reg_q;
  logic [IDX_W-1:0]          f_z_q;
  logic [IDX_W-1:0]          f_r_q;
  logic signed [FIELD_W-1:0] f_er_q;
  logic signed [FIELD_W-1:0] f_ez_q;

  logic                      take;
  logic                      op_known;
  logic                      drain;
  logic [31:0]               zq;
  logic [31:0]               rq;
  logic [31:0]               addr_full;
  logic [FIELD_W-1:0]        er_u;
  logic [FIELD_W-1:0]        ez_u;
  logic [FIELD_W-1:0]        mag_r;
  logic [FIELD_W-1:0]        mag_z;
  logic [2*FIELD_W-1:0]      sq_r_full;
  logic [2*FIELD_W-1:0]      sq_z_full;
  logic [PROD_W-1:0]         lim_r_full;
  logic [PROD_W-1:0]         lim_z_full;

  assign take     = s_valid_i & s_ready_o;
  assign op_known = (f_op_q == OP_CLEAR) || (f_op_q == OP_ACCUM) || (f_op_q == OP_THRESH);
  assign push_o   = f_valid_q & op_known;
  assign drain    = f_valid_q & (~op_known | push_ready_i);
  assign s_ready_o = en_i & (~f_valid_q | drain);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (take) begin
      f_valid_q <= 1'b1;
    end else if (drain) begin
      f_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      f_op_q  <= op_i;
      f_reg_q <= region_i;
      f_z_q   <= z_index_i;
      f_r_q   <= r_index_i;
      f_er_q  <= e_r_i;
      f_ez_q  <= e_z_i;
    end
  end

  always_comb begin
    zq = (32'(f_z_q) * 32'(DIV_RECIP)) >> DIV_SH;
    rq = (32'(f_r_q) * 32'(DIV_RECIP)) >> DIV_SH;
    addr_full = (32'(f_reg_q) * 32'(CELLS_Z) + zq) * 32'(CELLS_R) + rq;
  end

  always_comb begin
    er_u  = f_er_q;
    ez_u  = f_ez_q;
    mag_r = er_u[FIELD_W-1] ? (~er_u + FIELD_W'(1)) : er_u;
    mag_z = ez_u[FIELD_W-1] ? (~ez_u + FIELD_W'(1)) : ez_u;
    sq_r_full  = (2*FIELD_W)'(mag_r) * (2*FIELD_W)'(mag_z & '0 | mag_r);
    sq_z_full  = (2*FIELD_W)'(mag_z) * (2*FIELD_W)'(mag_z);
    lim_r_full = PROD_W'(mag_r) * PROD_W'(dyn_range_i);
    lim_z_full = PROD_W'(mag_z) * PROD_W'(dyn_range_i);
  end

  always_comb begin
    item_o.op        = op_e'(f_op_q);
    item_o.cell_ok   = (32'(f_reg_q) < 32'(NUM_REGIONS)) &&
                       (32'(f_z_q) < 32'(GRID_Z)) && (32'(f_r_q) < 32'(GRID_R));
    item_o.e_r       = f_er_q;
    item_o.e_z       = f_ez_q;
    item_o.sq_r      = sq_r_full[SQ_W-1:0];
    item_o.sq_z      = sq_z_full[SQ_W-1:0];
    item_o.lim_r     = lim_r_full[LIM_W-1:0];
    item_o.lim_z     = lim_z_full[LIM_W-1:0];
    item_o.lim_r_big = |lim_r_full[PROD_W-1:LIM_W];
    item_o.lim_z_big = |lim_z_full[PROD_W-1:LIM_W];
    addr_o           = addr_full[ADDR_W-1:0];
  end

endmodule

// ===== sv/lmdrt_queue.sv =====
// Short request queue between the front end and the back end.
module lmdrt_queue import lmdrt_pkg::*; #(
  parameter int unsigned ADDR_W = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              ready_o,
  input  item_t             item_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic              pop_i,
  output logic              nonempty_o,
  output item_t             item_o,
  output logic [ADDR_W-1:0] addr_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             item_q [QUEUE_DEPTH];
  logic [ADDR_W-1:0] addr_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_push;
  logic              do_pop;

  assign ready_o    = cnt_q != CNT_W'(QUEUE_DEPTH);
  assign nonempty_o = cnt_q != '0;
  assign do_push    = push_i & ready_o;
  assign do_pop     = pop_i & nonempty_o;
  assign item_o     = item_q[rd_ptr_q];
  assign addr_o     = addr_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      item_q[wr_ptr_q] <= item_i;
      addr_q[wr_ptr_q] <= addr_i;
    end
  end

endmodule

// ===== sv/lmdrt_back.sv =====
// Back end: cell maximum memory, clearing pass, read-modify-write and threshold result register.
module lmdrt_back import lmdrt_pkg::*; #(
  parameter int unsigned NUM_CELLS = 16384,
  parameter int unsigned ADDR_W    = 14
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [FLOOR_W-1:0]        floor_i,
  input  logic                      q_nonempty_i,
  input  item_t                     q_item_i,
  input  logic [ADDR_W-1:0]         q_addr_i,
  output logic                      pop_o,
  output logic                      init_done_o,
  output logic                      m_valid_o,
  input  logic                      m_ready_i,
  output logic signed [FIELD_W-1:0] e_r_out_o,
  output logic signed [FIELD_W-1:0] e_z_out_o,
  output logic                      e_r_zeroed_o,
  output logic                      e_z_zeroed_o,
  output logic                      below_floor_o
);

  logic [MAG2_W-1:0]         mem [NUM_CELLS];

  state_e                    state_q;
  state_e                    state_d;
  logic [ADDR_W-1:0]         clr_q;
  item_t                     w_q;
  logic [ADDR_W-1:0]         w_addr_q;
  logic [MAG2_W-1:0]         rdata_q;
  logic [MAG2_W-1:0]         sum_q;
  logic [MAG2_W-1:0]         cr2_q;
  logic [MAG2_W-1:0]         cz2_q;
  logic [FL2_W-1:0]          fl2_q;
  logic                      m_valid_q;
  logic signed [FIELD_W-1:0] e_r_out_q;
  logic signed [FIELD_W-1:0] e_z_out_q;
  logic                      zr_q;
  logic                      zz_q;
  logic                      below_q;

  logic                      clr_last;
  logic                      advance;
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr;
  logic [MAG2_W-1:0]         mem_wdata;
  logic                      out_load;
  logic [MAG2_W-1:0]         m2;
  logic                      below;
  logic                      zr;
  logic                      zz;

  assign clr_last    = clr_q == ADDR_W'(NUM_CELLS - 1);
  assign advance     = !((w_q.op == OP_THRESH) && m_valid_q && !m_ready_i);
  assign init_done_o = state_q != ST_CLEAR;

  always_comb begin
    m2    = w_q.cell_ok ? rdata_q : '0;
    below = !(m2 > MAG2_W'(fl2_q));
    zr    = below | (!w_q.lim_r_big && (cr2_q < m2));
    zz    = below | (!w_q.lim_z_big && (cz2_q < m2));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        if (q_nonempty_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (advance) state_d = ST_FETCH;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = w_addr_q;
    mem_wdata = sum_q;
    out_load  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      ST_FETCH: begin
        pop_o = q_nonempty_i;
      end
      ST_EXEC: begin
        if (advance) begin
          case (w_q.op)
            OP_CLEAR: begin
              mem_we    = w_q.cell_ok;
              mem_wdata = '0;
            end
            OP_ACCUM: begin
              mem_we = w_q.cell_ok && (sum_q > rdata_q);
            end
            OP_THRESH: begin
              out_load = 1'b1;
            end
            default: out_load = 1'b0;
          endcase
        end
      end
      default: pop_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (pop_o) begin
      rdata_q <= mem[q_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    fl2_q <= FL2_W'(floor_i) * FL2_W'(floor_i);
    if (pop_o) begin
      w_q      <= q_item_i;
      w_addr_q <= q_addr_i;
      sum_q    <= MAG2_W'(q_item_i.sq_r) + MAG2_W'(q_item_i.sq_z);
      cr2_q    <= MAG2_W'(q_item_i.lim_r) * MAG2_W'(q_item_i.lim_r);
      cz2_q    <= MAG2_W'(q_item_i.lim_z) * MAG2_W'(q_item_i.lim_z);
    end
    if (out_load) begin
      e_r_out_q <= zr ? '0 : w_q.e_r;
      e_z_out_q <= zz ? '0 : w_q.e_z;
      zr_q      <= zr;
      zz_q      <= zz;
      below_q   <= below;
    end
  end

  assign m_valid_o     = m_valid_q;
  assign e_r_out_o     = e_r_out_q;
  assign e_z_out_o     = e_z_out_q;
  assign e_r_zeroed_o  = zr_q;
  assign e_z_zeroed_o  = zz_q;
  assign below_floor_o = below_q;

endmodule

// ===== sv/local_max_dynamic_range_truncation_core.sv =====
// Top level: stream ports, configuration registers and front/queue/back hookup.
//
// Requests enter on the s_axis channel: tuser carries the op (clear cell, accumulate
// maximum, threshold sample), tdata the region, z and r grid indices and the two field
// components. Only threshold requests produce a result on m_axis: tdata carries both
// components after truncation, tuser the zeroed flags and the below-floor flag.
// The range ratio and the floor level are set through the APB port; write them only
// while no request is in flight.
// In the back end the fetch state reads the cell maximum from the single-port cell
// memory and squares the scaled limits, and the execute state compares and writes
// back or loads the result register; the next request is fetched only after that
// execute state ends, so requests do not overlap in the back end.
// After reset the cell memory is zeroed one entry per cycle (NUM_CELLS entries, 16384
// with default parameters); s_axis_tready stays low until that pass ends.
// When the result register is full and the receiver stalls, the back end holds the
// threshold request; the front register and the request queue keep taking requests
// until they fill up.
module local_max_dynamic_range_truncation_core import lmdrt_pkg::*; #(
  parameter int unsigned SUBSAMPLING = DEF_SUBSAMPLING,
  parameter int unsigned NUM_REGIONS = DEF_NUM_REGIONS,
  parameter int unsigned GRID_Z      = DEF_GRID_Z,
  parameter int unsigned GRID_R      = DEF_GRID_R
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // region[1:0], z_index[8:2], r_index[15:9], e_r[39:16], e_z[63:40]
  input  logic [63:0]           s_axis_tdata,
  // op[1:0]
  input  logic [OP_W-1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // e_r_out[23:0], e_z_out[47:24]
  output logic [47:0]           m_axis_tdata,
  // e_r_zeroed[0], e_z_zeroed[1], below_floor[2]
  output logic [2:0]            m_axis_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned CELLS_Z   = (GRID_Z + SUBSAMPLING - 1) / SUBSAMPLING;
  localparam int unsigned CELLS_R   = (GRID_R + SUBSAMPLING - 1) / SUBSAMPLING;
  localparam int unsigned NUM_CELLS = NUM_REGIONS * CELLS_Z * CELLS_R;
  localparam int unsigned ADDR_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  logic [DR_W-1:0]    dyn_range_q;
  logic [FLOOR_W-1:0] floor_q;
  logic               cfg_wr;

  logic               init_done;
  logic               q_push;
  logic               q_ready;
  item_t              q_in_item;
  logic [ADDR_W-1:0]  q_in_addr;
  logic               q_pop;
  logic               q_nonempty;
  item_t              q_out_item;
  logic [ADDR_W-1:0]  q_out_addr;

  logic signed [FIELD_W-1:0] e_r_out;
  logic signed [FIELD_W-1:0] e_z_out;
  logic                      e_r_zeroed;
  logic                      e_z_zeroed;
  logic                      below_floor;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dyn_range_q <= DYN_RANGE_RST;
      floor_q     <= FLOOR_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_DYN_RANGE: dyn_range_q <= pwdata[DR_W-1:0];
        REG_FLOOR:     floor_q     <= pwdata[FLOOR_W-1:0];
        default:       floor_q     <= floor_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DYN_RANGE: prdata = APB_DATA_W'(dyn_range_q);
      REG_FLOOR:     prdata = APB_DATA_W'(floor_q);
      default:       prdata = '0;
    endcase
  end

  lmdrt_front #(
    .SUBSAMPLING (SUBSAMPLING),
    .NUM_REGIONS (NUM_REGIONS),
    .GRID_Z      (GRID_Z),
    .GRID_R      (GRID_R),
    .CELLS_Z     (CELLS_Z),
    .CELLS_R     (CELLS_R),
    .ADDR_W      (ADDR_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (init_done),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .op_i         (s_axis_tuser),
    .region_i     (s_axis_tdata[1:0]),
    .z_index_i    (s_axis_tdata[8:2]),
    .r_index_i    (s_axis_tdata[15:9]),
    .e_r_i        (s_axis_tdata[39:16]),
    .e_z_i        (s_axis_tdata[63:40]),
    .dyn_range_i  (dyn_range_q),
    .push_o       (q_push),
    .push_ready_i (q_ready),
    .item_o       (q_in_item),
    .addr_o       (q_in_addr)
  );

  lmdrt_queue #(
    .ADDR_W (ADDR_W)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .ready_o    (q_ready),
    .item_i     (q_in_item),
    .addr_i     (q_in_addr),
    .pop_i      (q_pop),
    .nonempty_o (q_nonempty),
    .item_o     (q_out_item),
    .addr_o     (q_out_addr)
  );

  lmdrt_back #(
    .NUM_CELLS (NUM_CELLS),
    .ADDR_W    (ADDR_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .floor_i       (floor_q),
    .q_nonempty_i  (q_nonempty),
    .q_item_i      (q_out_item),
    .q_addr_i      (q_out_addr),
    .pop_o         (q_pop),
    .init_done_o   (init_done),
    .m_valid_o     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .e_r_out_o     (e_r_out),
    .e_z_out_o     (e_z_out),
    .e_r_zeroed_o  (e_r_zeroed),
    .e_z_zeroed_o  (e_z_zeroed),
    .below_floor_o (below_floor)
  );

  assign m_axis_tdata = {e_z_out, e_r_out};
  assign m_axis_tuser = {below_floor, e_z_zeroed, e_r_zeroed};

  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_done |-> !s_axis_tready)
    else $error("request taken during memory clearing pass");

  a_queue_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> q_ready || !(s_axis_tready && q_push && !q_ready))
    else $error("front pushed into a full queue");

  a_below_zeroes_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |->
      m_axis_tuser[0] && m_axis_tuser[1] && (m_axis_tdata == '0))
    else $error("below-floor result not fully zeroed");

  a_zeroed_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (!m_axis_tuser[0] || (m_axis_tdata[23:0] == '0)) &&
                      (!m_axis_tuser[1] || (m_axis_tdata[47:24] == '0)))
    else $error("zeroed flag set on a nonzero component");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking stream testbench for the local maximum dynamic-range truncation core.
`timescale 1ns / 1ps

module tb_top;
  import lmdrt_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [APB_ADDR_W-1:0] DR_ADDR    = {REG_DYN_RANGE, 2'b00};
  localparam logic [APB_ADDR_W-1:0] FLOOR_ADDR = {REG_FLOOR, 2'b00};
  localparam logic signed [FIELD_W-1:0] F_MAX = 24'h7FFFFF;
  localparam logic signed [FIELD_W-1:0] F_MIN = 24'h800000;
  localparam int CELLS          = 16384;
  localparam int DIRECTED_ROWS  = 16;
  localparam int RANDOM_PER_SET = 250;
  localparam int DRAIN_CYCLES   = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int QUIET_LIMIT    = 60000;

  typedef struct packed {
    logic signed [FIELD_W-1:0] e_r;
    logic signed [FIELD_W-1:0] e_z;
    logic                      r_zeroed;
    logic                      z_zeroed;
    logic                      below;
  } trunc_res_t;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic [REGION_W-1:0]       region;
    logic [IDX_W-1:0]          z;
    logic [IDX_W-1:0]          r;
    logic signed [FIELD_W-1:0] e_r;
    logic signed [FIELD_W-1:0] e_z;
    logic                      typed;
    trunc_res_t                res;
  } stim_row_t;

  localparam trunc_res_t FLOORED = '{e_r: '0, e_z: '0, r_zeroed: 1'b1, z_zeroed: 1'b1,
                                     below: 1'b1};
  localparam trunc_res_t NO_RES  = '0;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [63:0]           s_axis_tdata;
  logic [OP_W-1:0]       s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [47:0]           m_axis_tdata;
  logic [2:0]            m_axis_tuser;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic [MAG2_W-1:0]  cell_peak_sq [CELLS];
  logic [DR_W-1:0]    cfg_range;
  logic [FLOOR_W-1:0] cfg_floor;
  trunc_res_t         pending_results [$];
  stim_row_t          directed_rows [DIRECTED_ROWS];
  trunc_res_t         want_res;
  trunc_res_t         got_res;

  int  errors;
  int  results_checked;
  int  settings_used;
  int  quiet_cycles;
  int  op_count [4];
  bit  no_idle;
  bit  pressure_due;

  local_max_dynamic_range_truncation_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [MAG2_W-1:0] field_square(logic signed [FIELD_W-1:0] v);
    logic [FIELD_W-1:0] mag;
    mag = v[FIELD_W-1] ? FIELD_W'(-v) : v;
    return MAG2_W'(mag) * MAG2_W'(mag);
  endfunction

  function automatic bit under_limit(logic [MAG2_W-1:0] c2, logic [MAG2_W-1:0] m2,
                                     logic [DR_W-1:0] dr);
    logic [79:0] scaled;
    if (dr == '0) return 1'b1;
    scaled = 80'(c2) * 80'(dr) * 80'(dr);
    return scaled < 80'(m2);
  endfunction

  function automatic bit truncate_sample(logic [OP_W-1:0] op, logic [REGION_W-1:0] rg,
                                         logic [IDX_W-1:0] z, logic [IDX_W-1:0] r,
                                         logic signed [FIELD_W-1:0] er,
                                         logic signed [FIELD_W-1:0] ez,
                                         output trunc_res_t res);
    logic [13:0]       idx;
    logic [MAG2_W-1:0] sq_r;
    logic [MAG2_W-1:0] sq_z;
    logic [MAG2_W-1:0] peak;
    bit                has_res;
    idx     = {rg, z[IDX_W-1:1], r[IDX_W-1:1]};
    sq_r    = field_square(er);
    sq_z    = field_square(ez);
    res     = NO_RES;
    has_res = 1'b0;
    case (op)
      OP_CLEAR: begin
        cell_peak_sq[idx] = '0;
      end
      OP_ACCUM: begin
        if (sq_r + sq_z > cell_peak_sq[idx]) cell_peak_sq[idx] = sq_r + sq_z;
      end
      OP_THRESH: begin
        peak      = cell_peak_sq[idx];
        res.below = !(peak > MAG2_W'(cfg_floor) * MAG2_W'(cfg_floor));
        if (res.below) begin
          res.r_zeroed = 1'b1;
          res.z_zeroed = 1'b1;
        end else begin
          res.r_zeroed = under_limit(sq_r, peak, cfg_range);
          res.z_zeroed = under_limit(sq_z, peak, cfg_range);
        end
        res.e_r = res.r_zeroed ? '0 : er;
        res.e_z = res.z_zeroed ? '0 : ez;
        has_res = 1'b1;
      end
      default: ;
    endcase
    return has_res;
  endfunction

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [FIELD_W-1:0] rand_field();
    logic [FIELD_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = F_MAX;
      1: v = F_MIN;
      2: v = '0;
      3, 4, 5: v = FIELD_W'($urandom);
      default: begin
        v = FIELD_W'($urandom) >> $urandom_range(4, 22);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t mismatch %s: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic push_request(logic [OP_W-1:0] op, logic [REGION_W-1:0] rg,
                              logic [IDX_W-1:0] z, logic [IDX_W-1:0] r,
                              logic signed [FIELD_W-1:0] er, logic signed [FIELD_W-1:0] ez,
                              bit typed, trunc_res_t typed_res);
    trunc_res_t res;
    int         gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {ez, er, r, z, rg};
    do @(posedge clk_i); while (!s_axis_tready);
    op_count[op]++;
    if (truncate_sample(op, rg, z, r, er, ez, res))
      pending_results.push_back(typed ? typed_res : res);
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic random_burst(int count);
    logic [OP_W-1:0]     op;
    logic [REGION_W-1:0] rg;
    logic [IDX_W-1:0]    z;
    logic [IDX_W-1:0]    r;
    int                  pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) op = OP_CLEAR;
      else if (pick < 50) op = OP_ACCUM;
      else if (pick < 95) op = OP_THRESH;
      else op = OP_UNUSED;
      // keep most requests on a few cells so accumulate and threshold meet
      if ($urandom_range(0, 3) != 0) begin
        rg = REGION_W'($urandom_range(0, 1));
        z  = IDX_W'($urandom_range(0, 3));
        r  = IDX_W'($urandom_range(0, 3));
      end else begin
        rg = REGION_W'($urandom);
        z  = IDX_W'($urandom);
        r  = IDX_W'($urandom);
      end
      push_request(op, rg, z, r, rand_field(), rand_field(), 1'b0, NO_RES);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic config_register(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == DR_ADDR) cfg_range = DR_W'(value);
    else cfg_floor = FLOOR_W'(value);
    @(posedge clk_i);
    psel    <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    check_field(addr == DR_ADDR ? "range ratio readback" : "floor level readback",
                value, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (pressure_due) begin
        pressure_due = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat (no_idle ? 1 : $urandom_range(1, 8)) @(posedge clk_i);
      if (!no_idle && gap_len() > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = '{e_r: m_axis_tdata[23:0], e_z: m_axis_tdata[47:24],
                  r_zeroed: m_axis_tuser[0], z_zeroed: m_axis_tuser[1],
                  below: m_axis_tuser[2]};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result: expected none, got %0h", $time, got_res);
      end else begin
        want_res = pending_results.pop_front();
        check_field("e_r_out", 32'(want_res.e_r), 32'(got_res.e_r));
        check_field("e_z_out", 32'(want_res.e_z), 32'(got_res.e_z));
        check_field("e_r_zeroed", 32'(want_res.r_zeroed), 32'(got_res.r_zeroed));
        check_field("e_z_zeroed", 32'(want_res.z_zeroed), 32'(got_res.z_zeroed));
        check_field("below_floor", 32'(want_res.below), 32'(got_res.below));
      end
      results_checked++;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [DR_W-1:0]    set_range [6];
    logic [FLOOR_W-1:0] set_floor [6];
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    errors          = 0;
    results_checked = 0;
    settings_used   = 1;
    quiet_cycles    = 0;
    op_count        = '{default: 0};
    no_idle         = 1'b0;
    pressure_due    = 1'b0;
    cfg_range       = DYN_RANGE_RST;
    cfg_floor       = FLOOR_RST;
    foreach (cell_peak_sq[i]) cell_peak_sq[i] = '0;

    directed_rows[0]  = '{OP_THRESH, 2'd0, 7'd0, 7'd0, F_MAX, F_MIN, 1'b1, FLOORED};
    directed_rows[1]  = '{OP_ACCUM, 2'd0, 7'd0, 7'd0, F_MIN, F_MIN, 1'b0, NO_RES};
    directed_rows[2]  = '{OP_THRESH, 2'd0, 7'd1, 7'd1, F_MAX, 24'sd0, 1'b0, NO_RES};
    directed_rows[3]  = '{OP_THRESH, 2'd0, 7'd0, 7'd0, 24'sd1, -24'sd1, 1'b0, NO_RES};
    directed_rows[4]  = '{OP_CLEAR, 2'd0, 7'd1, 7'd0, 24'sd0, 24'sd0, 1'b0, NO_RES};
    directed_rows[5]  = '{OP_THRESH, 2'd0, 7'd0, 7'd1, F_MIN, 24'sd1, 1'b1, FLOORED};
    directed_rows[6]  = '{OP_UNUSED, 2'd0, 7'd0, 7'd0, F_MAX, F_MAX, 1'b0, NO_RES};
    directed_rows[7]  = '{OP_THRESH, 2'd0, 7'd0, 7'd0, F_MAX, F_MAX, 1'b1, FLOORED};
    directed_rows[8]  = '{OP_ACCUM, 2'd3, 7'd127, 7'd127, 24'sd100, 24'sd0, 1'b0, NO_RES};
    directed_rows[9]  = '{OP_THRESH, 2'd3, 7'd126, 7'd126, 24'sd2, 24'sd1, 1'b0, NO_RES};
    directed_rows[10] = '{OP_ACCUM, 2'd3, 7'd127, 7'd127, 24'sd50, 24'sd0, 1'b0, NO_RES};
    directed_rows[11] = '{OP_THRESH, 2'd3, 7'd127, 7'd127, -24'sd2, -24'sd3, 1'b0, NO_RES};
    directed_rows[12] = '{OP_ACCUM, 2'd1, 7'd64, 7'd5, F_MAX, F_MAX, 1'b0, NO_RES};
    directed_rows[13] = '{OP_THRESH, 2'd1, 7'd65, 7'd4, F_MIN, F_MAX, 1'b0, NO_RES};
    directed_rows[14] = '{OP_THRESH, 2'd2, 7'd10, 7'd10, F_MAX, F_MAX, 1'b1, FLOORED};
    directed_rows[15] = '{OP_THRESH, 2'd1, 7'd64, 7'd4, 24'sd0, 24'sd0, 1'b0, NO_RES};

    set_range[0] = 10'd1023;  set_floor[0] = 23'h7FFFFF;
    set_range[1] = 10'd0;     set_floor[1] = 23'd0;
    set_range[2] = 10'd1;     set_floor[2] = 23'd0;
    set_range[3] = 10'd1023;  set_floor[3] = 23'd0;
    set_range[4] = DR_W'($urandom_range(2, 200));
    set_floor[4] = FLOOR_W'($urandom_range(0, 4095));
    set_range[5] = DR_W'($urandom_range(1, 1023));
    set_floor[5] = FLOOR_W'($urandom);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      push_request(directed_rows[i].op, directed_rows[i].region, directed_rows[i].z,
                   directed_rows[i].r, directed_rows[i].e_r, directed_rows[i].e_z,
                   directed_rows[i].typed, directed_rows[i].res);
    random_burst(RANDOM_PER_SET);

    for (int p = 0; p < 6; p++) begin
      drain();
      config_register(DR_ADDR, APB_DATA_W'(set_range[p]));
      config_register(FLOOR_ADDR, APB_DATA_W'(set_floor[p]));
      settings_used++;
      no_idle = (p == 3);
      if (p == 1) pressure_due = 1'b1;
      random_burst(RANDOM_PER_SET);
    end
    drain();

    $display("Checked %0d results from %0d clear, %0d accumulate, %0d threshold, %0d unused-op",
             results_checked, op_count[OP_CLEAR], op_count[OP_ACCUM], op_count[OP_THRESH],
             op_count[OP_UNUSED]);
    $display("requests across %0d register settings, with one long output hold-off",
             settings_used);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
